### rtl/ldq_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Field widths, operation codes, status codes and sequencer states that the
// indexed-removal deque core uses.
// ----------------------------------------------------------------------------
package ldq_pkg;

	localparam int OPCODE_W = 3;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_REMOVE     = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_DUMP       = 3'd5;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_POP_FIN,
		S_REM_CAP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_DUMP_RD,
		S_DUMP_EMIT
	} state_t;

endpackage

### rtl/list_deque_index_remove_core.sv
// ----------------------------------------------------------------------------
// Bounded deque with indexed removal
// A circular store of signed 32-bit entries with push and pop at both ends,
// removal at an index with gap closing, and a front-to-back dump.
// ----------------------------------------------------------------------------
// A command beat is taken on a rising edge where start is high and busy is
// low; opcode, value and position are sampled then. busy stays high until the
// cycle in which the last result of that command is presented. Each result
// beat is shown for exactly one cycle with strobe high, and the receiver
// cannot hold it off.
// Every command gives one result, except a dump of a non-empty list, which
// gives one result per entry from front to back; last marks the final one.
// The entry store is a single-port memory with registered read data, and one
// shared modulo adder forms every store address from the head position.
// Pushes and errors give their result from the decode state; a pop reads
// its entry in decode and gives it from the pop-finish state. A removal
// captures the removed entry, then moves each entry behind it one place
// forward; each shifted entry needs a read and a write on the one memory
// port. A dump alternates between reading an entry and emitting it. The
// next command can be taken on the edge that ends the last result beat.
// Reset empties the list and sets the head position to zero; the store
// contents are not cleared, as only occupied entries are ever read.
// ----------------------------------------------------------------------------
module list_deque_index_remove_core #(
	parameter int DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [ldq_pkg::OPCODE_W-1:0]   opcode,
	input  logic signed [ldq_pkg::DATA_W-1:0] value,
	input  logic [ldq_pkg::POS_W-1:0]      position,
	output logic                           strobe,
	output logic signed [ldq_pkg::DATA_W-1:0] data_out,
	output logic [ldq_pkg::STATUS_W-1:0]   status,
	output logic [ldq_pkg::OCC_W-1:0]      occupancy,
	output logic                           last
);

	import ldq_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	state_t state_q, state_d;

	logic [OPCODE_W-1:0]      op_q;
	logic [DATA_W-1:0]        val_q;
	logic [POS_W-1:0]         pos_q;
	logic [PW-1:0]            head_q, head_d;
	logic [CW-1:0]            count_q, count_d;
	logic [CW-1:0]            idx_q, idx_d, idx_inc;
	logic [DATA_W-1:0]        data_q, data_d;
	logic [DATA_W-1:0]        rd_data_q;
	logic [DATA_W-1:0]        mem [DEPTH];

	logic [PW-1:0]            off;
	logic [PW:0]              slot_sum;
	logic [PW-1:0]            slot_addr;
	logic                     mem_we;
	logic [DATA_W-1:0]        mem_wdata;
	logic                     full, empty, out_of_range;

	logic                     res_fire;
	logic [DATA_W-1:0]        res_data;
	status_t                  res_status;
	logic                     res_last;

	logic                     strobe_q;
	logic [DATA_W-1:0]        data_out_q;
	status_t                  status_q;
	logic [OCC_W-1:0]         occupancy_q;
	logic                     last_q;

	assign slot_sum  = {1'b0, head_q} + {1'b0, off};
	assign slot_addr = (slot_sum >= (PW+1)'(DEPTH)) ? PW'(slot_sum - (PW+1)'(DEPTH))
	                                                 : PW'(slot_sum);

	assign full         = (count_q == CW'(DEPTH));
	assign empty        = (count_q == '0);
	assign out_of_range = (XW'(pos_q) >= XW'(count_q));
	assign idx_inc      = idx_q + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			count_q  <= count_d;
			idx_q    <= idx_d;
			strobe_q <= res_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q  <= opcode;
			val_q <= value;
			pos_q <= position;
		end
		data_q <= data_d;
		if (res_fire) begin
			data_out_q  <= res_data;
			status_q    <= res_status;
			occupancy_q <= OCC_W'(count_d);
			last_q      <= res_last;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot_addr] <= mem_wdata;
		end
		rd_data_q <= mem[slot_addr];
	end

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		count_d    = count_q;
		idx_d      = idx_q;
		data_d     = data_q;
		off        = '0;
		mem_we     = 1'b0;
		mem_wdata  = val_q;
		res_fire   = 1'b0;
		res_data   = '0;
		res_status = ST_OK;
		res_last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				case (op_q)
					OP_PUSH_FRONT: begin
						res_fire = 1'b1;
						if (full) begin
							res_status = ST_FULL;
						end else begin
							off     = PW'(DEPTH - 1);
							mem_we  = 1'b1;
							head_d  = slot_addr;
							count_d = count_q + CW'(1);
						end
					end
					OP_PUSH_BACK: begin
						res_fire = 1'b1;
						if (full) begin
							res_status = ST_FULL;
						end else begin
							off     = PW'(count_q);
							mem_we  = 1'b1;
							count_d = count_q + CW'(1);
						end
					end
					OP_POP_FRONT, OP_POP_BACK: begin
						if (empty) begin
							res_fire   = 1'b1;
							res_status = ST_EMPTY;
						end else begin
							off     = (op_q == OP_POP_BACK) ? PW'(count_q - CW'(1)) : '0;
							state_d = S_POP_FIN;
						end
					end
					OP_REMOVE: begin
						if (empty) begin
							res_fire   = 1'b1;
							res_status = ST_EMPTY;
						end else if (out_of_range) begin
							res_fire   = 1'b1;
							res_status = ST_RANGE;
						end else begin
							off     = PW'(pos_q);
							idx_d   = CW'(pos_q);
							state_d = S_REM_CAP;
						end
					end
					OP_DUMP: begin
						if (empty) begin
							res_fire   = 1'b1;
							res_status = ST_EMPTY;
						end else begin
							idx_d   = '0;
							state_d = S_DUMP_RD;
						end
					end
					default: begin
						res_fire = 1'b1;
					end
				endcase
			end
			S_POP_FIN: begin
				res_fire = 1'b1;
				res_data = rd_data_q;
				count_d  = count_q - CW'(1);
				if (op_q == OP_POP_FRONT) begin
					off    = PW'(1);
					head_d = slot_addr;
				end
				state_d = S_IDLE;
			end
			S_REM_CAP: begin
				data_d  = rd_data_q;
				state_d = S_SHIFT_RD;
			end
			S_SHIFT_RD: begin
				if (idx_inc < count_q) begin
					off     = PW'(idx_inc);
					state_d = S_SHIFT_WR;
				end else begin
					res_fire = 1'b1;
					res_data = data_q;
					count_d  = count_q - CW'(1);
					state_d  = S_IDLE;
				end
			end
			S_SHIFT_WR: begin
				off       = PW'(idx_q);
				mem_we    = 1'b1;
				mem_wdata = rd_data_q;
				idx_d     = idx_inc;
				state_d   = S_SHIFT_RD;
			end
			S_DUMP_RD: begin
				off     = PW'(idx_q);
				state_d = S_DUMP_EMIT;
			end
			S_DUMP_EMIT: begin
				res_fire = 1'b1;
				res_data = rd_data_q;
				res_last = (idx_inc == count_q);
				idx_d    = idx_inc;
				state_d  = res_last ? S_IDLE : S_DUMP_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign strobe    = strobe_q;
	assign data_out  = data_out_q;
	assign status    = status_q;
	assign occupancy = occupancy_q;
	assign last      = last_q;

	// A result beat is only ever produced by work started in an earlier cycle.
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result beat without a command in progress");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds the store depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, head_q} < (PW+1)'(DEPTH))
		else $error("head position outside the store");

	a_error_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status != ST_OK) |-> (data_out == '0))
		else $error("error result carries non-zero data");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> !busy)
		else $error("final result beat while still busy");

endmodule
